/* rtl/rotation_matrix_generator_assert.svh */
// ----------------------------------------------------------------------------
// Rotation matrix generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_GENERATOR_ASSERT_SVH
`define ROTATION_MATRIX_GENERATOR_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define RMG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never hold.
`define RMG_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

/* rtl/rmg_pkg.sv */
// ----------------------------------------------------------------------------
// Rotation matrix generator package
// Widths, angle constants, the CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmg_pkg;

  // Angle constants in Q16.16 degrees.
  localparam logic [32:0] D360       = 33'd23592960;
  localparam logic [24:0] D90        = 25'd5898240;
  localparam logic [24:0] D180       = 25'd11796480;
  // Multiple of 360 degrees that makes any 32-bit angle non-negative.
  localparam logic [32:0] RED_OFFSET = 33'd2170552320;

  // Range reduction: eight conditional subtracts, two per stage.
  localparam int RED_BITS       = 8;
  localparam int RED_PER_STAGE  = 2;
  localparam int RED_STAGES     = RED_BITS / RED_PER_STAGE;

  // CORDIC: sixteen iterations, two per stage.
  localparam int CORDIC_ITER    = 16;
  localparam int ITER_PER_STAGE = 2;
  localparam int CORDIC_STAGES  = CORDIC_ITER / ITER_PER_STAGE;

  localparam int XW  = 34;   // CORDIC x and y, Q2.30 with headroom
  localparam int ZW  = 25;   // residual angle, Q16.16 degrees
  localparam int SCW = 17;   // sine and cosine after quadrant mapping
  localparam int AW  = 66;   // matrix accumulator
  localparam int MW  = 20;   // matrix entry, Q4.16

  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Register stages: input, reduction, quadrant, CORDIC, sin/cos, three
  // arithmetic stages and the result register.
  localparam int PIPE_DEPTH = 1 + RED_STAGES + 1 + CORDIC_STAGES + 1 + 4;
  localparam int POST_STAGE = 1 + RED_STAGES + 1 + CORDIC_STAGES;

  // Request fields that ride alongside the angle pipeline.
  typedef struct packed {
    logic               mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } side_t;

  // Arctangent of 2^-i in Q16.16 degrees.
  function automatic logic signed [ZW-1:0] atan_deg(input logic [3:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      4'd0:    a = 25'sd2949120;
      4'd1:    a = 25'sd1740967;
      4'd2:    a = 25'sd919879;
      4'd3:    a = 25'sd466945;
      4'd4:    a = 25'sd234379;
      4'd5:    a = 25'sd117304;
      4'd6:    a = 25'sd58666;
      4'd7:    a = 25'sd29335;
      4'd8:    a = 25'sd14668;
      4'd9:    a = 25'sd7334;
      4'd10:   a = 25'sd3667;
      4'd11:   a = 25'sd1833;
      4'd12:   a = 25'sd917;
      4'd13:   a = 25'sd458;
      4'd14:   a = 25'sd229;
      default: a = 25'sd115;
    endcase
    return a;
  endfunction

endpackage

/* rtl/rotation_matrix_generator.sv */
// Output: a beat accepted at a clock edge shows its matrix on m00..m22, with
// done high, for one cycle once it has passed every pipeline register stage.
// Throughput: one beat per cycle; busy stays low, set by a fully pipelined
// datapath of three CORDIC lanes, range reduction and a multiplier tree.
// Reset: rst clears the valid chain only; no matrix is in flight after it.
// ----------------------------------------------------------------------------
// Rotation matrix generator
// Builds a 3x3 rotation matrix from an axis and angle, or from Euler XYZ
// angles, with pipelined sine and cosine lanes and a multiplier tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "rotation_matrix_generator_assert.svh"

module rotation_matrix_generator
  import rmg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  mode,
  input  logic signed [31:0]    angle_deg,
  input  logic signed [31:0]    vec_x,
  input  logic signed [31:0]    vec_y,
  input  logic signed [31:0]    vec_z,
  output logic                  done,
  output logic signed [MW-1:0]  m00,
  output logic signed [MW-1:0]  m01,
  output logic signed [MW-1:0]  m02,
  output logic signed [MW-1:0]  m10,
  output logic signed [MW-1:0]  m11,
  output logic signed [MW-1:0]  m12,
  output logic signed [MW-1:0]  m20,
  output logic signed [MW-1:0]  m21,
  output logic signed [MW-1:0]  m22
);

  // The pipeline never stalls, so a beat is taken every cycle.
  assign busy = 1'b0;

  // Valid bits travel with the data.
  logic [PIPE_DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_DEPTH-2:0], start & ~busy};
    end
  end

  assign done = vld[PIPE_DEPTH-1];

  // Side fields delayed alongside the angle lanes.
  side_t side [0:PIPE_DEPTH-2];

  always_ff @(posedge clk) begin
    side[0] <= '{mode: mode, x: vec_x, y: vec_y, z: vec_z};
    for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
      side[k] <= side[k-1];
    end
  end

  // Lane angles: lane 0 is the axis angle in mode 0 or Euler x in mode 1.
  logic signed [31:0] lane_deg [0:2];

  assign lane_deg[0] = mode ? vec_x : angle_deg;
  assign lane_deg[1] = vec_y;
  assign lane_deg[2] = vec_z;

  logic        [32:0]        red  [0:RED_STAGES][0:2];
  logic        [1:0]         cq   [0:CORDIC_STAGES][0:2];
  logic signed [XW-1:0]      cx   [0:CORDIC_STAGES][0:2];
  logic signed [XW-1:0]      cy   [0:CORDIC_STAGES][0:2];
  logic signed [ZW-1:0]      cz   [0:CORDIC_STAGES][0:2];
  logic signed [SCW-1:0]     sn   [0:2];
  logic signed [SCW-1:0]     cs   [0:2];

  for (genvar ln = 0; ln < 3; ln++) begin : g_lane

    // Offset the angle so that it is non-negative before reduction.
    always_ff @(posedge clk) begin
      red[0][ln] <= {lane_deg[ln][31], lane_deg[ln]} + RED_OFFSET;
    end

    // Reduce modulo 360 degrees, two quotient bits per stage.
    for (genvar st = 1; st <= RED_STAGES; st++) begin : g_red
      logic [32:0] rv;

      always_comb begin
        rv = red[st-1][ln];
        for (int j = 0; j < RED_PER_STAGE; j++) begin
          if (rv >= (D360 << (RED_BITS - 1 - (st - 1) * RED_PER_STAGE - j))) begin
            rv = rv - (D360 << (RED_BITS - 1 - (st - 1) * RED_PER_STAGE - j));
          end
        end
      end

      always_ff @(posedge clk) begin
        red[st][ln] <= rv;
      end
    end

    // Split into a quadrant and a remainder below 90 degrees.
    logic [24:0] rq;
    logic [1:0]  qv;

    always_comb begin
      rq = red[RED_STAGES][ln][24:0];
      qv = 2'd0;
      if (rq >= D180) begin
        rq    = rq - D180;
        qv[1] = 1'b1;
      end
      if (rq >= D90) begin
        rq    = rq - D90;
        qv[0] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      cq[0][ln] <= qv;
      cx[0][ln] <= CORDIC_GAIN;
      cy[0][ln] <= '0;
      cz[0][ln] <= $signed(rq);
    end

    // CORDIC rotation, two iterations per stage.
    for (genvar st = 1; st <= CORDIC_STAGES; st++) begin : g_cordic
      logic signed [XW-1:0] xv;
      logic signed [XW-1:0] yv;
      logic signed [ZW-1:0] zv;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;

      always_comb begin
        xv = cx[st-1][ln];
        yv = cy[st-1][ln];
        zv = cz[st-1][ln];
        dx = '0;
        dy = '0;
        for (int j = 0; j < ITER_PER_STAGE; j++) begin
          dx = yv >>> ((st - 1) * ITER_PER_STAGE + j);
          dy = xv >>> ((st - 1) * ITER_PER_STAGE + j);
          if (zv >= 0) begin
            xv = xv - dx;
            yv = yv + dy;
            zv = zv - atan_deg(4'((st - 1) * ITER_PER_STAGE + j));
          end else begin
            xv = xv + dx;
            yv = yv - dy;
            zv = zv + atan_deg(4'((st - 1) * ITER_PER_STAGE + j));
          end
        end
      end

      always_ff @(posedge clk) begin
        cx[st][ln] <= xv;
        cy[st][ln] <= yv;
        cz[st][ln] <= zv;
        cq[st][ln] <= cq[st-1][ln];
      end
    end

    // Round to Q1.15, clamp and map the quadrant onto the full circle.
    logic signed [XW-1:0]  xr;
    logic signed [XW-1:0]  yr;
    logic signed [SCW-1:0] c15;
    logic signed [SCW-1:0] s15;

    always_comb begin
      xr = (cx[CORDIC_STAGES][ln] + 34'sd16384) >>> 15;
      yr = (cy[CORDIC_STAGES][ln] + 34'sd16384) >>> 15;
      if (xr > 34'sd32767) begin
        c15 = 17'sd32767;
      end else if (xr < -34'sd32768) begin
        c15 = -17'sd32768;
      end else begin
        c15 = xr[SCW-1:0];
      end
      if (yr > 34'sd32767) begin
        s15 = 17'sd32767;
      end else if (yr < -34'sd32768) begin
        s15 = -17'sd32768;
      end else begin
        s15 = yr[SCW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      unique case (cq[CORDIC_STAGES][ln])
        2'd0: begin
          sn[ln] <= s15;
          cs[ln] <= c15;
        end
        2'd1: begin
          sn[ln] <= c15;
          cs[ln] <= -s15;
        end
        2'd2: begin
          sn[ln] <= -s15;
          cs[ln] <= -c15;
        end
        default: begin
          sn[ln] <= -c15;
          cs[ln] <= s15;
        end
      endcase
    end

    // Reduction and CORDIC invariants per lane.
    `RMG_ASSERT_IMPL(a_red_range, vld[RED_STAGES], red[RED_STAGES][ln] < D360,
                     "angle reduction left a value at or above 360 degrees")
    `RMG_ASSERT_IMPL(a_quad_range, vld[RED_STAGES+1],
                     (cz[0][ln] >= 0) && (cz[0][ln] < $signed({1'b0, D90})),
                     "quadrant remainder outside zero to 90 degrees")
    `RMG_ASSERT_IMPL(a_sc_range, vld[POST_STAGE],
                     (sn[ln] >= -17'sd32767) && (cs[ln] >= -17'sd32767),
                     "sine or cosine below the Q1.15 range")
  end

  // First arithmetic stage: axis products, t, and Euler pair products.
  side_t                 s1;
  logic signed [17:0]    m1_t;
  logic signed [SCW-1:0] m1_s;
  logic signed [SCW-1:0] m1_c;
  logic signed [47:0]    m1_xx, m1_yy, m1_zz, m1_xy, m1_xz, m1_yz;
  logic signed [33:0]    m1_sxsy, m1_cxsy, m1_cxsz, m1_cxcz, m1_sxsz, m1_sxcz;
  logic signed [33:0]    m1_cycz, m1_cysz, m1_sxcy, m1_cxcy;
  logic signed [SCW-1:0] m1_sy, m1_sz, m1_cz;

  function automatic logic signed [47:0] prod_q16(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = a * b;
    r = (p + 64'sd32768) >>> 16;
    return r[47:0];
  endfunction

  assign s1 = side[POST_STAGE];

  always_ff @(posedge clk) begin
    m1_t    <= 18'sd32768 - 18'(cs[0]);
    m1_s    <= sn[0];
    m1_c    <= cs[0];
    m1_xx   <= prod_q16(s1.x, s1.x);
    m1_yy   <= prod_q16(s1.y, s1.y);
    m1_zz   <= prod_q16(s1.z, s1.z);
    m1_xy   <= prod_q16(s1.x, s1.y);
    m1_xz   <= prod_q16(s1.x, s1.z);
    m1_yz   <= prod_q16(s1.y, s1.z);
    m1_sxsy <= sn[0] * sn[1];
    m1_cxsy <= cs[0] * sn[1];
    m1_cxsz <= cs[0] * sn[2];
    m1_cxcz <= cs[0] * cs[2];
    m1_sxsz <= sn[0] * sn[2];
    m1_sxcz <= sn[0] * cs[2];
    m1_cycz <= cs[1] * cs[2];
    m1_cysz <= cs[1] * sn[2];
    m1_sxcy <= sn[0] * cs[1];
    m1_cxcy <= cs[0] * cs[1];
    m1_sy   <= sn[1];
    m1_sz   <= sn[2];
    m1_cz   <= cs[2];
  end

  // Second arithmetic stage: the two terms of each entry.
  side_t                s2;
  logic signed [AW-1:0] av [0:8];
  logic signed [AW-1:0] bv [0:8];
  logic signed [AW-1:0] m2_a [0:8];
  logic signed [AW-1:0] m2_b [0:8];
  logic signed [AW-1:0] cw;

  assign s2 = side[POST_STAGE+1];

  always_comb begin
    cw = AW'(m1_c) <<< 16;
    if (!s2.mode) begin
      av[0] = m1_t * m1_xx;  bv[0] = cw;
      av[1] = m1_t * m1_xy;  bv[1] = m1_s * s2.z;
      av[2] = m1_t * m1_xz;  bv[2] = -(m1_s * s2.y);
      av[3] = m1_t * m1_xy;  bv[3] = -(m1_s * s2.z);
      av[4] = m1_t * m1_yy;  bv[4] = cw;
      av[5] = m1_t * m1_yz;  bv[5] = m1_s * s2.x;
      av[6] = m1_t * m1_xz;  bv[6] = m1_s * s2.y;
      av[7] = m1_t * m1_yz;  bv[7] = -(m1_s * s2.x);
      av[8] = m1_t * m1_zz;  bv[8] = cw;
    end else begin
      av[0] = AW'(m1_cycz) <<< 15;    bv[0] = '0;
      av[1] = AW'(m1_cysz) <<< 15;    bv[1] = '0;
      av[2] = -(AW'(m1_sy) <<< 30);   bv[2] = '0;
      av[3] = m1_sxsy * m1_cz;        bv[3] = -(AW'(m1_cxsz) <<< 15);
      av[4] = m1_sxsy * m1_sz;        bv[4] = AW'(m1_cxcz) <<< 15;
      av[5] = AW'(m1_sxcy) <<< 15;    bv[5] = '0;
      av[6] = m1_cxsy * m1_cz;        bv[6] = AW'(m1_sxsz) <<< 15;
      av[7] = m1_cxsy * m1_sz;        bv[7] = -(AW'(m1_sxcz) <<< 15);
      av[8] = AW'(m1_cxcy) <<< 15;    bv[8] = '0;
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) begin
      m2_a[e] <= av[e];
      m2_b[e] <= bv[e];
    end
  end

  // Third arithmetic stage: sum the terms.
  logic signed [AW-1:0] acc [0:8];

  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) begin
      acc[e] <= m2_a[e] + m2_b[e];
    end
  end

  // Result stage: round half up, then saturate to Q4.16.
  side_t                s4;
  logic signed [AW-1:0] rnd [0:8];
  logic signed [MW-1:0] res [0:8];

  assign s4 = side[POST_STAGE+3];

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      if (s4.mode) begin
        rnd[e] = (acc[e] + (AW'(1) <<< 28)) >>> 29;
      end else begin
        rnd[e] = (acc[e] + (AW'(1) <<< 14)) >>> 15;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 9; e++) begin
      if (rnd[e] > AW'(524287)) begin
        res[e] <= 20'sd524287;
      end else if (rnd[e] < -AW'(524288)) begin
        res[e] <= -20'sd524288;
      end else begin
        res[e] <= rnd[e][MW-1:0];
      end
    end
  end

  assign m00 = res[0];
  assign m01 = res[1];
  assign m02 = res[2];
  assign m10 = res[3];
  assign m11 = res[4];
  assign m12 = res[5];
  assign m20 = res[6];
  assign m21 = res[7];
  assign m22 = res[8];

  // No beat is ever refused.
  `RMG_ASSERT_NEVER(a_never_busy, busy, "busy raised on a stall-free pipeline")

endmodule

/* tb/rotation_matrix_generator_tb.sv */
// ----------------------------------------------------------------------------
// Rotation matrix generator testbench
// Sends axis-angle and Euler XYZ requests, with random gaps and back to back,
// and checks each returned matrix against a cycle-free predictor in this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_generator_tb;
  import rmg_pkg::*;

  localparam logic MODE_AXIS  = 1'b0;
  localparam logic MODE_EULER = 1'b1;
  localparam int   N_RANDOM   = 780;
  localparam int   DRAIN      = 40;
  localparam longint DEG_FULL = 64'sd23592960;
  localparam longint DEG_QTR  = 64'sd5898240;
  localparam int   ONE_Q16    = 65536;

  typedef logic signed [MW-1:0] ent_t;
  typedef struct {ent_t e [9];} matrix_t;
  typedef struct {
    logic mode;
    logic signed [31:0] ang;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic has_fixed;
    logic signed [MW-1:0] fixed [9];
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = 1'b0;
  logic signed [31:0] angle_deg = '0, vec_x = '0, vec_y = '0, vec_z = '0;
  logic done;
  logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  matrix_t pending_mats[$];
  int errors = 0;
  beat_t directed [$];

  always #5 clk = ~clk;

  rotation_matrix_generator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .angle_deg(angle_deg), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .done(done), .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
    .m12(m12), .m20(m20), .m21(m21), .m22(m22)
  );

  // Arctangent of 2^-i, Q16.16 degrees.
  function automatic longint atan_step(int i);
    longint tbl [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                         58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                         229, 115};
    return tbl[i];
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Sine and cosine in Q1.15 from Q16.16 degrees.
  function automatic void trig(input longint deg, output longint sn,
                               output longint cs);
    longint r, q, cx, cy, cz, dx, dy, s15, c15;
    r = deg % DEG_FULL;
    if (r < 0) r += DEG_FULL;
    q = r / DEG_QTR;
    cz = r % DEG_QTR;
    cx = 652032874;
    cy = 0;
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= atan_step(i);
      end else begin
        cx += dx; cy -= dy; cz += atan_step(i);
      end
    end
    c15 = clip(rnd_shift(cx, 15), -32768, 32767);
    s15 = clip(rnd_shift(cy, 15), -32768, 32767);
    case (q)
      0: begin sn = s15;  cs = c15;  end
      1: begin sn = c15;  cs = -s15; end
      2: begin sn = -s15; cs = -c15; end
      default: begin sn = -c15; cs = s15; end
    endcase
  endfunction

  function automatic ent_t sat(longint v, int s);
    return ent_t'(clip(rnd_shift(v, s), -524288, 524287));
  endfunction

  // Expected matrix for one request.
  function automatic matrix_t rotation(beat_t b);
    matrix_t m;
    longint x, y, z, s, c, t, cw, xx, yy, zz, xy, xz, yz;
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    x = b.x; y = b.y; z = b.z;
    if (b.mode == MODE_AXIS) begin
      trig(longint'(b.ang), s, c);
      t = 32768 - c;
      cw = c * 65536;
      xx = rnd_shift(x * x, 16); yy = rnd_shift(y * y, 16);
      zz = rnd_shift(z * z, 16); xy = rnd_shift(x * y, 16);
      xz = rnd_shift(x * z, 16); yz = rnd_shift(y * z, 16);
      m.e[0] = sat(t * xx + cw, 15);
      m.e[1] = sat(t * xy + s * z, 15);
      m.e[2] = sat(t * xz - s * y, 15);
      m.e[3] = sat(t * xy - s * z, 15);
      m.e[4] = sat(t * yy + cw, 15);
      m.e[5] = sat(t * yz + s * x, 15);
      m.e[6] = sat(t * xz + s * y, 15);
      m.e[7] = sat(t * yz - s * x, 15);
      m.e[8] = sat(t * zz + cw, 15);
    end else begin
      trig(x, sx, cx);
      trig(y, sy, cy);
      trig(z, sz, cz);
      sxsy = sx * sy;
      cxsy = cx * sy;
      m.e[0] = sat(cy * cz, 14);
      m.e[1] = sat(cy * sz, 14);
      m.e[2] = ent_t'(clip(-sy * 2, -524288, 524287));
      m.e[3] = sat(sxsy * cz - cx * sz * 32768, 29);
      m.e[4] = sat(sxsy * sz + cx * cz * 32768, 29);
      m.e[5] = sat(sx * cy, 14);
      m.e[6] = sat(cxsy * cz + sx * sz * 32768, 29);
      m.e[7] = sat(cxsy * sz - sx * cz * 32768, 29);
      m.e[8] = sat(cx * cy, 14);
    end
    return m;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic beat_t row(logic md, int a, int x, int y, int z);
    beat_t b;
    b.mode = md; b.ang = a; b.x = x; b.y = y; b.z = z;
    b.has_fixed = 1'b0;
    foreach (b.fixed[i]) b.fixed[i] = '0;
    return b;
  endfunction

  function automatic beat_t row_fixed(logic md, int a, int x, int y, int z,
                                      int f0, int f1, int f2, int f3, int f4,
                                      int f5, int f6, int f7, int f8);
    beat_t b;
    b = row(md, a, x, y, z);
    b.has_fixed = 1'b1;
    b.fixed = '{f0, f1, f2, f3, f4, f5, f6, f7, f8};
    return b;
  endfunction

  // Random Q16.16 value: mostly small angles or unit-ish axes, some full range.
  function automatic int pick(bit is_axis);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return int'($urandom);
    if (is_axis) return $signed($urandom_range(0, 2 * ONE_Q16)) - ONE_Q16;
    return $signed($urandom_range(0, 2 * 23592960)) - 23592960;
  endfunction

  // Drive one beat; the sender idles at random unless gaps are off.
  task automatic send(beat_t b, bit gaps);
    matrix_t m;
    while (gaps && $urandom_range(0, 99) < 21) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= b.mode; angle_deg <= b.ang;
    vec_x <= b.x; vec_y <= b.y; vec_z <= b.z;
    @(posedge clk);
    while (busy) @(posedge clk);
    m = rotation(b);
    if (b.has_fixed) begin
      foreach (m.e[i])
        if (m.e[i] !== b.fixed[i]) begin
          report($sformatf("predictor disagrees with table entry %0d", i));
          m.e[i] = b.fixed[i];
        end
    end
    pending_mats.push_back(m);
  endtask

  // Result monitor: each done beat is checked against the oldest matrix.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_mats.size() == 0) begin
        report("matrix with none expected");
      end else begin
        matrix_t w;
        ent_t got [9];
        w = pending_mats.pop_front();
        got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        foreach (got[i])
          if (got[i] !== w.e[i])
            report($sformatf("entry %0d got %0d want %0d", i, got[i], w.e[i]));
      end
    end
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    // Directed rows: the expected matrices of the identity cases are typed in
    // exactly. At zero degrees the sine comes out as -1 LSB and the cosine clamps to 32767.
    directed.push_back(row_fixed(MODE_AXIS, 0, ONE_Q16, 0, 0,
      65536, 0, 0, 0, 65534, -2, 0, 2, 65534));
    directed.push_back(row_fixed(MODE_EULER, 0, 0, 0, 0,
      65532, -2, 2, 2, 65532, -2, -2, 2, 65532));
    directed.push_back(row_fixed(MODE_AXIS, 0, 0, 0, 0,
      65534, 0, 0, 0, 65534, 0, 0, 0, 65534));
    directed.push_back(row(MODE_AXIS, 90 * ONE_Q16, 0, 0, ONE_Q16));
    directed.push_back(row(MODE_AXIS, 180 * ONE_Q16, ONE_Q16, 0, 0));
    directed.push_back(row(MODE_AXIS, 270 * ONE_Q16, 0, ONE_Q16, 0));
    directed.push_back(row(MODE_AXIS, -90 * ONE_Q16, 0, 0, ONE_Q16));
    directed.push_back(row(MODE_AXIS, 360 * ONE_Q16, ONE_Q16, ONE_Q16, 0));
    directed.push_back(row(MODE_AXIS, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff));
    directed.push_back(row(MODE_AXIS, 32'h80000000, 32'h80000000,
      32'h80000000, 32'h80000000));
    directed.push_back(row(MODE_AXIS, 45 * ONE_Q16, 32'h80000000,
      32'h7fffffff, -1));
    directed.push_back(row(MODE_AXIS, 30 * ONE_Q16, 4 * ONE_Q16, -4 * ONE_Q16, 1));
    directed.push_back(row(MODE_AXIS, -1, 8 * ONE_Q16, 8 * ONE_Q16, -8 * ONE_Q16));
    directed.push_back(row(MODE_EULER, 32'h7fffffff, 90 * ONE_Q16,
      0, 0));
    directed.push_back(row(MODE_EULER, 0, 0, 90 * ONE_Q16, 0));
    directed.push_back(row(MODE_EULER, 0, 0, 0, 90 * ONE_Q16));
    directed.push_back(row(MODE_EULER, -1, 180 * ONE_Q16, -90 * ONE_Q16,
      270 * ONE_Q16));
    directed.push_back(row(MODE_EULER, 0, 32'h7fffffff, 32'h80000000, -1));
    directed.push_back(row(MODE_EULER, 0, 32'h80000000, 32'h7fffffff, 1));
    directed.push_back(row(MODE_EULER, 0, 45 * ONE_Q16, 30 * ONE_Q16,
      60 * ONE_Q16));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send(directed[i], 1'b1);

    // Random requests; a middle stretch runs back to back.
    for (int n = 0; n < N_RANDOM; n++) begin
      beat_t b;
      bit axis;
      axis = $urandom_range(0, 1);
      b = row(axis ? MODE_AXIS : MODE_EULER, pick(1'b0), pick(axis),
              pick(axis), pick(axis));
      if (n == N_RANDOM / 2) begin
        // Hold off until the pipeline has drained.
        start <= 1'b0;
        while (pending_mats.size() != 0) @(posedge clk);
      end
      send(b, !(n >= 200 && n < 320));
    end
    start <= 1'b0;

    while (pending_mats.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rmg_pkg.sv
rtl/rotation_matrix_generator.sv
tb/rotation_matrix_generator_tb.sv
